// ===== rtl/motion_adaptive_point_averager_assert.svh =====
// assertion macros shared by the point averager rtl
`ifndef MOTION_ADAPTIVE_POINT_AVERAGER_ASSERT_SVH
`define MOTION_ADAPTIVE_POINT_AVERAGER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MAPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MAPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mapa_pkg.sv =====
// shared types and constants of the motion adaptive point averager
package mapa_pkg;

  localparam int COORD_W    = 24;
  localparam int THR_W      = 24;
  localparam int LEN_CFG_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  // squared 25-bit magnitude, and the sum of three of them
  localparam int DIST_W     = 2 * (COORD_W + 1);
  localparam int NUM_AXES   = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0] axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_STATIC_LEN = 2'd1,
    CFG_MOVING_LEN = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLASS,
    ST_DROP_CHK,
    ST_DROP_SUB,
    ST_APPEND,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic classify;
    logic drop_rd;
    logic drop_sub;
    logic append;
    logic div_start;
    logic div_store;
    logic out_load;
  } ctrl_t;

endpackage

// ===== rtl/mapa_point_if.sv =====
// input point channel
interface mapa_point_if import mapa_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// ===== rtl/mapa_mean_if.sv =====
// smoothed mean channel
interface mapa_mean_if import mapa_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t mean_x;
  coord_t mean_y;
  coord_t mean_z;

  modport source (output valid, output mean_x, output mean_y, output mean_z, input ready);
  modport sink (input valid, input mean_x, input mean_y, input mean_z, output ready);
endinterface

// ===== rtl/mapa_cfg_if.sv =====
// configuration write channel
interface mapa_cfg_if import mapa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mapa_divider.sv =====
// serial restoring divider, signed dividend by unsigned divisor, truncates toward zero
module mapa_divider #(
  parameter int SUM_W = 30,
  parameter int CNT_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic        [CNT_W-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [SUM_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle on the magnitude
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      quo_q <= dividend_i[SUM_W-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== rtl/motion_adaptive_point_averager.sv =====
// motion adaptive point averager: top level with sequencer, window memory and sums
// usage:
//   point_i carries one 3D point (signed, 8 fraction bits) per transfer; mean_o
//   returns one smoothed point per input point, in order; cfg_i writes the
//   distance threshold (index 0), static window length (1) and moving window
//   length (2) and is always ready; write it only while the block is idle.
// sequence:
//   point_i is ready only while the sequencer is idle, one point at a time.
//   a point takes a multiply step for each axis and one for the threshold, a
//   classify step, a drop check with a read and a subtract per dropped
//   sample, an append step, three serial divisions (sum width = 24 +
//   log2(WINDOW_DEPTH)) on the shared serial divider, and an output step.
// stalls and reset:
//   the finished mean waits in an output register, so the next point is taken
//   while mean_o is stalled; a point only waits at its end if that register is
//   still full. reset restores the default registers, clears sums, count, last
//   mean and class (static); window memory needs no clearing.
`include "motion_adaptive_point_averager_assert.svh"

module motion_adaptive_point_averager import mapa_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mapa_point_if.sink   point_i,
  mapa_mean_if.source  mean_o,
  mapa_cfg_if.sink     cfg_i
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = COORD_W + IDX_W;
  localparam int LEN_W = (CNT_W > LEN_CFG_W) ? CNT_W : LEN_CFG_W;
  localparam int MEM_W = NUM_AXES * COORD_W;

  localparam logic [LEN_W-1:0] DEPTH_L  = LEN_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W:0]   SLOT_WRAP = (CNT_W + 1)'(WINDOW_DEPTH);
  localparam axis_t            AXIS_LAST = axis_t'(NUM_AXES - 1);

  // sequencer
  state_e state_q, state_d;
  ctrl_t  ctrl;

  // configuration registers
  logic [THR_W-1:0]     thr_q;
  logic [LEN_CFG_W-1:0] static_len_q;
  logic [LEN_CFG_W-1:0] moving_len_q;

  // per-point working state
  coord_t            p_q [NUM_AXES];
  logic [1:0]        mul_cnt_q;
  logic [DIST_W-1:0] prod_q;
  logic [DIST_W-1:0] dist_q;
  logic [CNT_W-1:0]  len_q;
  axis_t             axis_q;

  // filter state
  coord_t                  last_mean_q [NUM_AXES];
  logic signed [SUM_W-1:0] sum_q [NUM_AXES];
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        oldest_q;
  logic                    mode_q;

  // window memory, one word holds x, y and z
  logic [MEM_W-1:0] win_mem [WINDOW_DEPTH];
  logic [MEM_W-1:0] rd_q;

  // output register
  logic   out_valid_q;
  coord_t mean_x_q, mean_y_q, mean_z_q;

  // shared datapath signals
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        mul_op;
  logic [DIST_W-1:0]       prod;
  logic                    moving;
  logic                    drop_need;
  logic [LEN_W-1:0]        len_sel;
  logic [LEN_W-1:0]        len_clamped;
  logic [CNT_W:0]          slot_sum;
  logic [IDX_W-1:0]        slot;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  // square of the axis difference from the last mean, then of the threshold
  always_comb begin
    diff   = '0;
    mul_op = '0;
    case (mul_cnt_q)
      2'd3: mul_op = {1'b0, thr_q};
      default: begin
        diff   = {last_mean_q[mul_cnt_q][COORD_W-1], last_mean_q[mul_cnt_q]}
               - {p_q[mul_cnt_q][COORD_W-1], p_q[mul_cnt_q]};
        mul_op = diff[COORD_W] ? $unsigned(-diff) : $unsigned(diff);
      end
    endcase
  end

  assign prod = DIST_W'(mul_op) * DIST_W'(mul_op);

  // static when strictly inside the threshold sphere
  assign moving = !(dist_q < prod_q);

  // zero acts as one, above the depth acts as the depth
  assign len_sel = moving ? LEN_W'(moving_len_q) : LEN_W'(static_len_q);
  always_comb begin
    if (len_sel == '0) begin
      len_clamped = LEN_ONE;
    end else if (len_sel > DEPTH_L) begin
      len_clamped = DEPTH_L;
    end else begin
      len_clamped = len_sel;
    end
  end

  assign drop_need = (count_q >= len_q) && (count_q != '0);

  // write slot just past the newest sample, wrapped around the ring
  assign slot_sum = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
  always_comb begin
    if (slot_sum >= SLOT_WRAP) begin
      slot = IDX_W'(slot_sum - SLOT_WRAP);
    end else begin
      slot = IDX_W'(slot_sum);
    end
  end

  mapa_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (sum_q[axis_q]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (point_i.valid) state_d = ST_MUL;
      ST_MUL:      if (mul_cnt_q == 2'd3) state_d = ST_CLASS;
      ST_CLASS:    state_d = ST_DROP_CHK;
      ST_DROP_CHK: state_d = drop_need ? ST_DROP_SUB : ST_APPEND;
      ST_DROP_SUB: state_d = ST_DROP_CHK;
      ST_APPEND:   state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (axis_q == AXIS_LAST) ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_OUT:      if (!out_valid_q || mean_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:     ctrl.load = point_i.valid;
      ST_MUL: begin
        ctrl.mul = 1'b1;
        ctrl.acc = (mul_cnt_q != 2'd0);
      end
      ST_CLASS:    ctrl.classify = 1'b1;
      ST_DROP_CHK: ctrl.drop_rd = drop_need;
      ST_DROP_SUB: ctrl.drop_sub = 1'b1;
      ST_APPEND:   ctrl.append = 1'b1;
      ST_DIV_GO:   ctrl.div_start = 1'b1;
      ST_DIV_WAIT: ctrl.div_store = div_done;
      ST_OUT:      ctrl.out_load = !out_valid_q || mean_o.ready;
      default:     ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_W'(2560);
      static_len_q <= LEN_CFG_W'(30);
      moving_len_q <= LEN_CFG_W'(50);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_THRESHOLD:  thr_q        <= cfg_i.data[THR_W-1:0];
        CFG_STATIC_LEN: static_len_q <= cfg_i.data[LEN_CFG_W-1:0];
        CFG_MOVING_LEN: moving_len_q <= cfg_i.data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // filter state and sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q   <= '0;
      axis_q      <= '0;
      len_q       <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        last_mean_q[a] <= '0;
        sum_q[a]       <= '0;
      end
    end else begin
      if (ctrl.load) begin
        mul_cnt_q <= '0;
      end
      if (ctrl.mul) begin
        mul_cnt_q <= mul_cnt_q + 1'b1;
      end
      // class change empties the window
      if (ctrl.classify) begin
        if (moving != mode_q) begin
          count_q  <= '0;
          oldest_q <= '0;
          for (int a = 0; a < NUM_AXES; a++) begin
            sum_q[a] <= '0;
          end
        end
        mode_q <= moving;
        len_q  <= CNT_W'(len_clamped);
      end
      // retire the oldest sample read out last cycle
      if (ctrl.drop_sub) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_q[a] <= sum_q[a] - {{(SUM_W - COORD_W){rd_q[a*COORD_W + COORD_W - 1]}},
                                  rd_q[a*COORD_W +: COORD_W]};
        end
        oldest_q <= (oldest_q == IDX_LAST) ? '0 : oldest_q + 1'b1;
        count_q  <= count_q - 1'b1;
      end
      if (ctrl.append) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_q[a] <= sum_q[a] + {{(SUM_W - COORD_W){p_q[a][COORD_W-1]}}, p_q[a]};
        end
        count_q <= count_q + 1'b1;
        axis_q  <= '0;
      end
      if (ctrl.div_store) begin
        last_mean_q[axis_q] <= div_quot[COORD_W-1:0];
        axis_q              <= axis_q + 1'b1;
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (mean_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      p_q[0] <= point_i.point_x;
      p_q[1] <= point_i.point_y;
      p_q[2] <= point_i.point_z;
      dist_q <= '0;
    end
    if (ctrl.mul) begin
      prod_q <= prod;
      if (ctrl.acc) begin
        dist_q <= dist_q + prod_q;
      end
    end
    if (ctrl.out_load) begin
      mean_x_q <= last_mean_q[0];
      mean_y_q <= last_mean_q[1];
      mean_z_q <= last_mean_q[2];
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl.append) begin
      win_mem[slot] <= {p_q[2], p_q[1], p_q[0]};
    end
    if (ctrl.drop_rd) begin
      rd_q <= win_mem[oldest_q];
    end
  end

  assign point_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign mean_o.valid  = out_valid_q;
  assign mean_o.mean_x = mean_x_q;
  assign mean_o.mean_y = mean_y_q;
  assign mean_o.mean_z = mean_z_q;

  // window never holds more samples than the memory has entries
  `MAPA_ASSERT_NOW(a_count_in_depth, 1'b1, count_q <= CNT_W'(WINDOW_DEPTH), "window count above depth")
  // a point is taken only once the previous one is done
  `MAPA_ASSERT_NEXT(a_one_point, point_i.valid && point_i.ready, !point_i.ready, "point taken while busy")
  // a division result only arrives while the sequencer waits for it
  `MAPA_ASSERT_NOW(a_div_expected, div_done, state_q == ST_DIV_WAIT, "unexpected divider result")
  // after the append the window is non-empty and within its length
  `MAPA_ASSERT_NEXT(a_append_len, state_q == ST_APPEND, (count_q != '0) && (count_q <= len_q), "window length broken after append")

endmodule

// ===== bench/tb_motion_adaptive_point_averager.sv =====
// self-checking testbench of the motion adaptive point averager
`timescale 1ns / 1ps

module tb_motion_adaptive_point_averager;
  import mapa_pkg::*;

  localparam int     WINDOW_DEPTH = 64;
  localparam int     CLK_PERIOD   = 20;
  localparam int     COORD_MAX    = 8388607;
  localparam int     COORD_MIN    = -8388608;
  localparam int     SETTLE_CYCLES = 300;
  localparam int     HOLD_CYCLES   = 2500;
  localparam longint LIMIT_NS      = 64'd4_000_000 * CLK_PERIOD;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // how both sides of the block idle within one phase
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  // ways the point generator leaves its smooth track
  typedef enum int {
    JOLT_NONE, JOLT_SWEEP, JOLT_JUMP, JOLT_RANDOM, JOLT_EXTREME, JOLT_EDGE
  } jolt_e;

  logic clk_i;
  logic rst_ni;

  mapa_point_if point_if ();
  mapa_mean_if  mean_if ();
  mapa_cfg_if   cfg_if ();

  motion_adaptive_point_averager #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(point_if),
    .mean_o (mean_if),
    .cfg_i  (cfg_if)
  );

  // points waiting to be offered, and means the block still owes us
  point_t pending_points [$];
  point_t expected_means [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  bit hold_go;
  bit mean_hold;

  int error_count;
  int accepted_points;
  int checked_means;
  int setting_count;

  // predictor copy of the registers
  logic [23:0] threshold_reg;
  logic [6:0]  static_len_reg;
  logic [6:0]  moving_len_reg;

  // predictor copy of the averaging state
  coord_t last_mean [NUM_AXES];
  coord_t window_mem [NUM_AXES][WINDOW_DEPTH];
  longint axis_sum [NUM_AXES];
  int     sample_count;
  int     oldest_slot;
  logic   moving_mode;

  // point generator state, kept across phases so a phase can continue a window
  int gen_center [NUM_AXES];
  int gen_velocity [NUM_AXES];
  bit gen_sweeping;
  int corner_values [4] = '{COORD_MAX, COORD_MIN, 0, -1};

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // reset once at the start, every block input known from time zero
  initial begin : reset_seq
    int a;
    rst_ni          = 1'b0;
    point_if.valid  = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    point_if.point_z = '0;
    mean_if.ready   = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_THRESHOLD;
    cfg_if.data     = '0;
    threshold_reg   = 24'd2560;
    static_len_reg  = 7'd30;
    moving_len_reg  = 7'd50;
    for (a = 0; a < NUM_AXES; a++) begin
      last_mean[a]    = '0;
      axis_sum[a]     = 0;
      gen_center[a]   = 0;
      gen_velocity[a] = 0;
    end
    sample_count = 0;
    oldest_slot  = 0;
    moving_mode  = 1'b0;
    gen_sweeping = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // expected mean for one accepted point, advancing the predictor state
  function automatic point_t advance_averager(input point_t pt);
    coord_t pc [NUM_AXES];
    coord_t mean [NUM_AXES];
    longint diff;
    longint dist_sq;
    longint thr_sq;
    logic   moving;
    int     win_len;
    int     slot;
    int     a;
    pc[0] = pt.x;
    pc[1] = pt.y;
    pc[2] = pt.z;
    dist_sq = 0;
    for (a = 0; a < NUM_AXES; a++) begin
      diff = longint'(last_mean[a]) - longint'(pc[a]);
      dist_sq += diff * diff;
    end
    thr_sq = longint'(threshold_reg) * longint'(threshold_reg);
    // static only when strictly inside the threshold sphere
    moving = (dist_sq >= thr_sq);
    // a change of class empties the window
    if (moving != moving_mode) begin
      for (a = 0; a < NUM_AXES; a++) axis_sum[a] = 0;
      sample_count = 0;
      oldest_slot  = 0;
    end
    moving_mode = moving;
    win_len = moving ? int'(moving_len_reg) : int'(static_len_reg);
    if (win_len < 1) win_len = 1;
    if (win_len > WINDOW_DEPTH) win_len = WINDOW_DEPTH;
    // drop oldest until there is room, more than one after a length cut
    while (sample_count >= win_len) begin
      for (a = 0; a < NUM_AXES; a++) axis_sum[a] -= longint'(window_mem[a][oldest_slot]);
      oldest_slot = (oldest_slot + 1) % WINDOW_DEPTH;
      sample_count--;
    end
    slot = (oldest_slot + sample_count) % WINDOW_DEPTH;
    for (a = 0; a < NUM_AXES; a++) begin
      window_mem[a][slot] = pc[a];
      axis_sum[a] += longint'(pc[a]);
    end
    sample_count++;
    // signed division truncates toward zero
    for (a = 0; a < NUM_AXES; a++) begin
      mean[a]      = coord_t'(axis_sum[a] / sample_count);
      last_mean[a] = mean[a];
    end
    return '{mean[0], mean[1], mean[2]};
  endfunction

  function automatic coord_t clip_coord(input longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("[%0t] mean check: %s", $time, what);
    error_count++;
  endtask

  // add one point at the tail of the pending queue
  task automatic queue_point(input int x, input int y, input int z);
    point_t pt;
    pt = '{coord_t'(x), coord_t'(y), coord_t'(z)};
    pending_points = {pending_points, pt};
  endtask

  // point driver: predicts on every accepted transfer, then offers the next point
  always @(posedge clk_i or negedge rst_ni) begin : point_driver
    point_t next_point;
    point_t predicted;
    if (!rst_ni) begin
      point_if.valid <= 1'b0;
    end else begin
      if (point_if.valid && point_if.ready) begin
        predicted = advance_averager(
          '{point_if.point_x, point_if.point_y, point_if.point_z});
        expected_means = {expected_means, predicted};
        accepted_points++;
      end
      // a held point stays up; a free slot gets a new point or an idle cycle
      if (!point_if.valid || point_if.ready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_point = pending_points.pop_front();
          point_if.valid   <= 1'b1;
          point_if.point_x <= next_point.x;
          point_if.point_y <= next_point.y;
          point_if.point_z <= next_point.z;
        end else begin
          point_if.valid <= 1'b0;
        end
      end
    end
  end

  // mean monitor: compares each mean transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : mean_monitor
    point_t want;
    if (!rst_ni) begin
      mean_if.ready <= 1'b0;
    end else begin
      if (mean_if.valid && mean_if.ready) begin
        if (expected_means.size() == 0) begin
          report_mismatch("mean transfer with no point outstanding");
        end else begin
          want = expected_means.pop_front();
          checked_means++;
          if (mean_if.mean_x !== want.x)
            report_mismatch($sformatf("mean_x %0d, expected %0d", mean_if.mean_x, want.x));
          if (mean_if.mean_y !== want.y)
            report_mismatch($sformatf("mean_y %0d, expected %0d", mean_if.mean_y, want.y));
          if (mean_if.mean_z !== want.z)
            report_mismatch($sformatf("mean_z %0d, expected %0d", mean_if.mean_z, want.z));
        end
      end
      mean_if.ready <= !mean_hold && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // long receiver hold-off, counted here so the block backs up into its input
  initial begin : receiver_hold
    mean_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    mean_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    mean_hold <= 1'b0;
  end

  // register write, only issued while the block is idle
  task automatic write_register(input cfg_reg_e idx, input int value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_THRESHOLD:  threshold_reg  = value[23:0];
      CFG_STATIC_LEN: static_len_reg = value[6:0];
      CFG_MOVING_LEN: moving_len_reg = value[6:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // all points in, all means out, then a latency's worth of quiet
  task automatic wait_idle();
    while (pending_points.size() != 0 || point_if.valid || expected_means.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly a noisy track around a center that now and then sweeps or jumps,
  // so both static and moving windows fill up; the rest is noise
  task automatic queue_random_points(input int n, input int disrupt_pct);
    point_t pt;
    longint spot [NUM_AXES];
    jolt_e  kind;
    int     amp;
    int     span;
    int     vmag;
    int     k;
    int     a;
    // a quarter of the threshold keeps a point static around a settled mean
    amp = int'(threshold_reg) / 4;
    if (amp < 1) amp = 1;
    if (amp > (1 << 22)) amp = 1 << 22;
    for (k = 0; k < n; k++) begin
      kind = JOLT_NONE;
      if ($urandom_range(99) < disrupt_pct)
        kind = jolt_e'($urandom_range(JOLT_SWEEP, JOLT_EDGE));
      if (kind == JOLT_SWEEP) begin
        gen_sweeping = !gen_sweeping;
        for (a = 0; a < NUM_AXES; a++) begin
          vmag = int'(threshold_reg) + int'($urandom_range(int'(threshold_reg)));
          if (vmag > (1 << 20)) vmag = 1 << 20;
          if (vmag < 1) vmag = 1;
          gen_velocity[a] = $urandom_range(1) ? vmag : -vmag;
        end
      end else if (kind == JOLT_JUMP) begin
        for (a = 0; a < NUM_AXES; a++) gen_center[a] = int'(coord_t'($urandom));
      end
      // a sweep outruns the lagging mean and keeps the class moving
      if (gen_sweeping) begin
        for (a = 0; a < NUM_AXES; a++) begin
          gen_center[a] += gen_velocity[a];
          if (gen_center[a] > 8000000 || gen_center[a] < -8000000) begin
            gen_velocity[a] = -gen_velocity[a];
            gen_center[a]   = int'(clip_coord(gen_center[a]));
          end
        end
      end
      // edge noise lands around the threshold distance
      span = (kind == JOLT_EDGE) ? 3 * amp : amp;
      for (a = 0; a < NUM_AXES; a++) begin
        case (kind)
          JOLT_RANDOM:  spot[a] = longint'(coord_t'($urandom));
          JOLT_EXTREME: spot[a] = corner_values[$urandom_range(3)];
          default: spot[a] = longint'(gen_center[a]) + longint'($urandom_range(2 * span)) - span;
        endcase
      end
      pt = '{clip_coord(spot[0]), clip_coord(spot[1]), clip_coord(spot[2])};
      pending_points = {pending_points, pt};
    end
  endtask

  // one register setting: write all three, set idling, stream points, drain
  task automatic run_phase(input int thr, input int slen, input int mlen, input idle_e mode,
                           input int n, input int disrupt_pct, input bit with_hold);
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_STATIC_LEN, slen);
    write_register(CFG_MOVING_LEN, mlen);
    setting_count++;
    sender_idle_pct    <= (mode == IDLE_SENDER) ? 88 : (mode == IDLE_BOTH) ? 11 : 0;
    receiver_stall_pct <= (mode == IDLE_RECEIVER) ? 88 : (mode == IDLE_BOTH) ? 11 : 0;
    // a quiet phase starts on a still track so its static window can fill
    if (disrupt_pct < 5) gen_sweeping = 1'b0;
    @(negedge clk_i);
    queue_random_points(n, disrupt_pct);
    if (with_hold) hold_go = 1'b1;
    wait_idle();
  endtask

  initial begin : stimulus
    int k;
    int thr;
    int slen;
    int mlen;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // directed points at the reset settings (threshold 10.0, lengths 30 and 50)
    queue_point(0, 0, 0);                                // first point, static
    queue_point(256, -256, 100);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);        // moving, window cleared
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);        // back to static
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(-8388607, COORD_MIN, -8388607);          // odd negative sums
    queue_point(-8388605, -8388600, COORD_MIN);
    queue_point(COORD_MAX, COORD_MIN, 0);
    queue_point(-1, -1, -1);
    queue_point(-2, 1, -3);                              // truncation toward zero
    queue_point(2796201, -2796202, -1);                  // on the mean, static again
    queue_point(0, 0, 0);                                // moving, mean back to zero
    queue_point(2559, 0, 0);                             // just inside, static again
    queue_point(5118, 0, 0);                             // just inside it
    queue_point(6398, 0, 0);                             // exactly on it, moving
    queue_point(5592405, -5592406, 5592405);             // alternating bit patterns
    queue_point(-5592406, 5592405, -5592406);
    wait_idle();

    // reset values written back explicitly
    run_phase(2560, 30, 50, IDLE_NONE, 200, 12, 1'b0);
    // quiet static track fills the full 64-deep window
    run_phase(1024, 64, 64, IDLE_SENDER, 220, 1, 1'b0);
    // static length cut mid-stream, many samples dropped at once
    run_phase(1024, 2, 64, IDLE_RECEIVER, 150, 12, 1'b0);
    // zero threshold: always moving; zero static length, oversize moving length
    run_phase(0, 0, 127, IDLE_BOTH, 150, 12, 1'b0);
    // moving length cut to one while the window is full
    run_phase(0, 10, 1, IDLE_NONE, 150, 12, 1'b0);
    // full-scale threshold, oversize static length, zero moving length
    run_phase(16777215, 127, 0, IDLE_SENDER, 150, 1, 1'b0);
    // long output hold-off backs the block up
    run_phase(300, 5, 3, IDLE_RECEIVER, 200, 12, 1'b1);

    // random settings, lengths mostly within the window depth
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(3))
        0:       thr = $urandom_range(1, 64);
        1:       thr = $urandom_range(256, 8192);
        2:       thr = $urandom_range(8192, 1 << 20);
        default: thr = $urandom_range(1) ? 0 : 16777215;
      endcase
      slen = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      mlen = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      run_phase(thr, slen, mlen, idle_e'(k), 170, 12, 1'b0);
    end

    $display("run covered %0d points and %0d means across %0d register settings",
             accepted_points, checked_means, setting_count);
    $display("including zero and oversize lengths, zero and full-scale thresholds, %0s",
             "window cuts mid-stream and a long output hold-off");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("run limit reached with %0d means outstanding", expected_means.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mapa_pkg.sv
rtl/mapa_point_if.sv
rtl/mapa_mean_if.sv
rtl/mapa_cfg_if.sv
rtl/mapa_divider.sv
rtl/motion_adaptive_point_averager.sv
bench/tb_motion_adaptive_point_averager.sv
